FILE: rtl/core/ekq_pkg.sv
// Shared types, constants and saturating helpers for the elastodynamic kernel quadrature block.
// Used by every module under rtl/core; depends on nothing.
package ekq_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int NUM_PAIRS     = 6;

    typedef enum logic [2:0] {
        CFG_EXT_X,
        CFG_EXT_Y,
        CFG_EXT_Z,
        CFG_TIME_NOW,
        CFG_SPEED_P,
        CFG_SPEED_S
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] ext_x;
        logic signed [31:0] ext_y;
        logic signed [31:0] ext_z;
        logic signed [31:0] time_now;
        logic        [30:0] speed_p;
        logic        [30:0] speed_s;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] node_x;
        logic signed [31:0] node_y;
        logic signed [31:0] node_z;
        logic signed [31:0] weight;
        logic               last;
    } node_t;

    typedef struct packed {
        logic signed [63:0] m_xx;
        logic signed [63:0] m_yy;
        logic signed [63:0] m_zz;
        logic signed [63:0] m_xy;
        logic signed [63:0] m_xz;
        logic signed [63:0] m_yz;
        logic               overflow;
    } result_t;

    typedef struct packed {
        logic signed [31:0] d_x;
        logic signed [31:0] d_y;
        logic signed [31:0] d_z;
        logic signed [31:0] weight;
        logic               last;
        logic               dsat;
    } qent_t;

    typedef struct packed {
        logic signed [63:0] val;
        logic               ovf;
    } sat_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_ACTP,
        ST_ACTS,
        ST_DIP,
        ST_DIS,
        ST_DRP,
        ST_DRS,
        ST_DR1,
        ST_TT,
        ST_P1,
        ST_S1,
        ST_RP2,
        ST_RS2,
        ST_W,
        ST_W2,
        ST_I2,
        ST_I3,
        ST_I4,
        ST_I5,
        ST_DA,
        ST_DB,
        ST_XX,
        ST_A1,
        ST_A,
        ST_B1,
        ST_B2,
        ST_B,
        ST_E,
        ST_PW,
        ST_FIN
    } state_t;

    function automatic sat_t qadd(input logic signed [63:0] a, input logic signed [63:0] b);
        sat_t res;
        logic signed [63:0] s;
        s = a + b;
        res.val = s;
        res.ovf = 1'b0;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            res.ovf = 1'b1;
            res.val = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end
        return res;
    endfunction

    function automatic sat_t qsub(input logic signed [63:0] a, input logic signed [63:0] b);
        sat_t res;
        logic signed [63:0] s;
        s = a - b;
        res.val = s;
        res.ovf = 1'b0;
        if ((a[63] != b[63]) && (s[63] != a[63])) begin
            res.ovf = 1'b1;
            res.val = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end
        return res;
    endfunction

    // row and column of each of the six distinct kernel entries: xx yy zz xy xz yz
    function automatic logic [1:0] pair_row(input logic [2:0] k);
        logic [1:0] v;
        case (k)
            3'd0:    v = 2'd0;
            3'd1:    v = 2'd1;
            3'd2:    v = 2'd2;
            3'd5:    v = 2'd1;
            default: v = 2'd0;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pair_col(input logic [2:0] k);
        logic [1:0] v;
        case (k)
            3'd0:    v = 2'd0;
            3'd1:    v = 2'd1;
            3'd2:    v = 2'd2;
            3'd3:    v = 2'd1;
            default: v = 2'd2;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/ekq_front.sv
// Front end: takes node transfers, forms the saturated distance vector to the external point.
// Depends on ekq_pkg; feeds ekq_queue.
module ekq_front (
    input  ekq_pkg::node_t node,
    input  logic           node_valid,
    output logic           node_stall,
    input  ekq_pkg::cfg_t  cfg,
    input  logic           q_full,
    output logic           q_push,
    output ekq_pkg::qent_t q_data
);
    import ekq_pkg::*;

    logic sx, sy, sz;
    logic signed [31:0] dx, dy, dz;

    function automatic logic signed [32:0] diff33(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [32:0] d);
        logic signed [31:0] v;
        if (d[32] != d[31]) begin
            v = d[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
        end
        else begin
            v = d[31:0];
        end
        return v;
    endfunction

    always_comb
    begin
        logic signed [32:0] ex, ey, ez;
        ex = diff33(node.node_x, cfg.ext_x);
        ey = diff33(node.node_y, cfg.ext_y);
        ez = diff33(node.node_z, cfg.ext_z);
        sx = ex[32] != ex[31];
        sy = ey[32] != ey[31];
        sz = ez[32] != ez[31];
        dx = clamp32(ex);
        dy = clamp32(ey);
        dz = clamp32(ez);
    end

    assign node_stall    = q_full;
    assign q_push        = node_valid & ~q_full;
    assign q_data.d_x    = dx;
    assign q_data.d_y    = dy;
    assign q_data.d_z    = dz;
    assign q_data.weight = node.weight;
    assign q_data.last   = node.last;
    assign q_data.dsat   = sx | sy | sz;

endmodule

FILE: rtl/core/ekq_queue.sv
// Short queue between front and back end, holding the node entries formed by the front end.
// Depends on ekq_pkg.
module ekq_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ekq_pkg::qent_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output ekq_pkg::qent_t pop_data
);
    import ekq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    qent_t          mem [QUEUE_DEPTH];
    logic [AW-1:0]  wr_reg, wr_next;
    logic [AW-1:0]  rd_reg, rd_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        logic [AW-1:0] n;
        if (p == AW'(QUEUE_DEPTH - 1)) begin
            n = '0;
        end
        else begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    assign full      = (cnt_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem[rd_reg];

    always_comb
    begin
        wr_next  = push ? bump(wr_reg) : wr_reg;
        rd_next  = pop ? bump(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/ekq_mul.sv
// Shared multiplier: 64x64 signed magnitude product from four 32x32 partial products,
// optional fraction shift, saturation to 64 bits. Depends on ekq_pkg.
module ekq_mul #(
    parameter int FRAC_BITS = ekq_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    input  logic               shift_en,
    output logic               done,
    output logic signed [63:0] res,
    output logic               sat
);
    import ekq_pkg::*;

    logic         busy_reg;
    logic [2:0]   cnt_reg;
    logic         done_reg;
    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg, sh_reg;
    logic [127:0] acc_reg;
    logic signed [63:0] res_reg;
    logic         sat_reg;

    logic [31:0]  ah, bh;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] shifted;
    logic [63:0]  lo, limit, lo_sat;
    logic         ovf;

    always_comb
    begin
        ah = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        bh = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp = 64'(ah) * 64'(bh);
        case ({cnt_reg[1], cnt_reg[0]})
            2'b00:   pp_sh = 128'(pp);
            2'b11:   pp_sh = 128'(pp) << 64;
            default: pp_sh = 128'(pp) << 32;
        endcase
        shifted = sh_reg ? (acc_reg >> FRAC_BITS) : acc_reg;
        lo      = shifted[63:0];
        limit   = neg_reg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        ovf     = (shifted[127:64] != '0) || (lo > limit);
        lo_sat  = ovf ? limit : lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= a[63] ? 64'(-a) : 64'(a);
            mb_reg  <= b[63] ? 64'(-b) : 64'(b);
            neg_reg <= a[63] ^ b[63];
            sh_reg  <= shift_en;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 3'd4)
            begin
                res_reg <= neg_reg ? -$signed(lo_sat) : $signed(lo_sat);
                sat_reg <= ovf;
            end
            else
            begin
                acc_reg <= acc_reg + pp_sh;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;
    assign sat  = sat_reg;

endmodule

FILE: rtl/core/ekq_div.sv
// Shared restoring divider: 64-bit unsigned numerator over 32-bit divisor, one bit a cycle.
// Depends on ekq_pkg.
module ekq_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [63:0] quot
);
    import ekq_pkg::*;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [63:0] num_reg;
    logic [31:0] den_reg;
    logic [31:0] rem_reg;
    logic [63:0] quot_reg;

    logic [32:0] rem_sh, rem_new;
    logic        ge;

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[63]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_new = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[62:0], 1'b0};
            rem_reg  <= rem_new[31:0];
            quot_reg <= {quot_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: rtl/core/ekq_sqrt.sv
// Floor square root of a 64-bit unsigned value, one result bit a cycle.
// Depends on ekq_pkg.
module ekq_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] val,
    output logic        done,
    output logic [31:0] root
);
    import ekq_pkg::*;

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic        done_reg;
    logic [63:0] v_reg, res_reg, bit_reg;

    logic [63:0] trial;
    logic        ge;

    always_comb
    begin
        trial = res_reg + bit_reg;
        ge    = v_reg >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= val;
            res_reg <= '0;
            bit_reg <= 64'(1) << 62;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

FILE: rtl/core/ekq_back.sv
// Back end: sequencer that evaluates the kernel for one node on the shared multiplier,
// divider and square root unit, and accumulates the six entries. Depends on ekq_pkg,
// ekq_mul, ekq_div, ekq_sqrt.
module ekq_back #(
    parameter int FRAC_BITS = ekq_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ekq_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  ekq_pkg::qent_t   q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output ekq_pkg::result_t out_data
);
    import ekq_pkg::*;

    localparam logic signed [63:0] THREE  = 64'(3) << FRAC_BITS;
    localparam logic signed [63:0] HALF   = 64'(1) << (FRAC_BITS - 1);
    localparam logic        [63:0] NUM_2F = 64'(1) << (2 * FRAC_BITS);

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;
    logic   ovf_reg, ovf_next;
    logic   out_valid_reg, out_valid_next;
    logic [2:0] k_reg, k_next;
    logic signed [63:0] acc_reg [NUM_PAIRS];
    logic signed [63:0] acc_next [NUM_PAIRS];
    logic   load_out;

    logic signed [31:0] dx_reg, dy_reg, dz_reg, w_reg;
    logic               last_reg;
    logic [63:0]        sum_reg;
    logic [31:0]        r_reg;
    logic               act_p_reg, act_s_reg;
    logic signed [63:0] inv_p_reg, inv_s_reg, rp_reg, rs_reg, inv1_reg;
    logic signed [63:0] tt_reg, p1_reg, s1_reg, p2_reg, s2_reg, w1_reg, w2_reg;
    logic signed [63:0] inv3_reg, inv5_reg, diag_reg, tmp_reg, xx_reg, a_reg, e_reg;
    result_t            out_reg;

    logic               use_mul, use_div, use_sqrt, plain, skip, go;
    logic signed [63:0] mul_a, mul_b;
    logic               mul_sh;
    logic [63:0]        div_num;
    logic [31:0]        div_den;
    logic               mul_done, mul_sat, div_done, sqrt_done;
    logic signed [63:0] mres;
    logic [63:0]        dquot;
    logic [31:0]        sqrt_res;

    logic signed [63:0] t64, cp64, cs64;
    logic [30:0]        cp, cs;
    logic [63:0]        rsh;
    logic               t_pos;
    logic signed [63:0] d_row, d_col, d_k;
    sat_t               w1_s, w2a_s, p2_s, diag_s, e_s, e2_s, acc_s;

    function automatic logic signed [63:0] dsel(input logic [1:0] i,
                                                input logic signed [31:0] x,
                                                input logic signed [31:0] y,
                                                input logic signed [31:0] z);
        logic signed [63:0] v;
        case (i)
            2'd0:    v = 64'(x);
            2'd1:    v = 64'(y);
            default: v = 64'(z);
        endcase
        return v;
    endfunction

    always_comb
    begin
        cp    = (cfg.speed_p == '0) ? 31'd1 : cfg.speed_p;
        cs    = (cfg.speed_s == '0) ? 31'd1 : cfg.speed_s;
        cp64  = $signed(64'(cp));
        cs64  = $signed(64'(cs));
        t64   = 64'(cfg.time_now);
        t_pos = !cfg.time_now[31] && (cfg.time_now != '0);
        rsh   = 64'(r_reg) << FRAC_BITS;
        d_k   = dsel(k_reg[1:0], dx_reg, dy_reg, dz_reg);
        d_row = dsel(pair_row(k_reg), dx_reg, dy_reg, dz_reg);
        d_col = dsel(pair_col(k_reg), dx_reg, dy_reg, dz_reg);
        w1_s   = qsub(p1_reg, s1_reg);
        w2a_s  = qsub(p2_reg, s2_reg);
        p2_s   = qsub(tt_reg, mres);
        diag_s = qsub(tmp_reg, mres);
        e_s    = qadd(a_reg, mres);
        e2_s   = qadd(e_reg, diag_reg);
        acc_s  = qadd(acc_reg[k_reg], mres);
    end

    // operation decode
    always_comb
    begin
        use_mul  = 1'b0;
        use_div  = 1'b0;
        use_sqrt = 1'b0;
        plain    = 1'b0;
        skip     = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        mul_sh   = 1'b1;
        div_num  = '0;
        div_den  = '0;
        case (state_reg)
            ST_SQ:   begin use_mul = 1'b1; mul_a = d_k; mul_b = d_k; mul_sh = 1'b0; end
            ST_SQRT: begin use_sqrt = 1'b1; end
            ST_ACTP:
            begin
                use_mul = 1'b1; mul_a = t64; mul_b = cp64; mul_sh = 1'b0; skip = !t_pos;
            end
            ST_ACTS:
            begin
                use_mul = 1'b1; mul_a = t64; mul_b = cs64; mul_sh = 1'b0; skip = !t_pos;
            end
            ST_DIP:  begin use_div = 1'b1; div_num = NUM_2F; div_den = 32'(cp); end
            ST_DIS:  begin use_div = 1'b1; div_num = NUM_2F; div_den = 32'(cs); end
            ST_DRP:  begin use_div = 1'b1; div_num = rsh; div_den = 32'(cp); end
            ST_DRS:  begin use_div = 1'b1; div_num = rsh; div_den = 32'(cs); end
            ST_DR1:  begin use_div = 1'b1; div_num = NUM_2F; div_den = r_reg; end
            ST_TT:   begin use_mul = 1'b1; mul_a = t64; mul_b = t64; end
            ST_P1:
            begin
                use_mul = 1'b1; mul_a = inv_p_reg; mul_b = inv_p_reg; skip = !act_p_reg;
            end
            ST_S1:
            begin
                use_mul = 1'b1; mul_a = inv_s_reg; mul_b = inv_s_reg; skip = !act_s_reg;
            end
            ST_RP2:
            begin
                use_mul = 1'b1; mul_a = rp_reg; mul_b = rp_reg; skip = !act_p_reg;
            end
            ST_RS2:
            begin
                use_mul = 1'b1; mul_a = rs_reg; mul_b = rs_reg; skip = !act_s_reg;
            end
            ST_W:    begin plain = 1'b1; end
            ST_W2:   begin use_mul = 1'b1; mul_a = HALF; mul_b = tmp_reg; end
            ST_I2:   begin use_mul = 1'b1; mul_a = inv1_reg; mul_b = inv1_reg; end
            ST_I3:   begin use_mul = 1'b1; mul_a = tmp_reg; mul_b = inv1_reg; end
            ST_I4:   begin use_mul = 1'b1; mul_a = inv3_reg; mul_b = inv1_reg; end
            ST_I5:   begin use_mul = 1'b1; mul_a = tmp_reg; mul_b = inv1_reg; end
            ST_DA:   begin use_mul = 1'b1; mul_a = inv1_reg; mul_b = s1_reg; end
            ST_DB:   begin use_mul = 1'b1; mul_a = inv3_reg; mul_b = w2_reg; end
            ST_XX:   begin use_mul = 1'b1; mul_a = d_row; mul_b = d_col; end
            ST_A1:   begin use_mul = 1'b1; mul_a = xx_reg; mul_b = inv3_reg; end
            ST_A:    begin use_mul = 1'b1; mul_a = tmp_reg; mul_b = w1_reg; end
            ST_B1:   begin use_mul = 1'b1; mul_a = THREE; mul_b = xx_reg; end
            ST_B2:   begin use_mul = 1'b1; mul_a = tmp_reg; mul_b = inv5_reg; end
            ST_B:    begin use_mul = 1'b1; mul_a = tmp_reg; mul_b = w2_reg; end
            ST_E:    begin plain = 1'b1; end
            ST_PW:
            begin
                use_mul = 1'b1; mul_a = e_reg; mul_b = 64'(w_reg); mul_sh = 1'b0;
            end
            default: ;
        endcase
        go = skip | plain | (use_mul & mul_done) | (use_div & div_done)
             | (use_sqrt & sqrt_done);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        ovf_next       = ovf_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg & out_stall;
        q_pop          = 1'b0;
        load_out       = 1'b0;
        if ((use_mul | use_div | use_sqrt) && !skip && !issued_reg)
        begin
            issued_next = 1'b1;
        end
        if (go)
        begin
            issued_next = 1'b0;
        end
        if (mul_done)
        begin
            ovf_next = ovf_next | mul_sat;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    ovf_next   = ovf_next | q_data.dsat;
                    k_next     = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (go)
                begin
                    if (k_reg == 3'd2)
                    begin
                        k_next     = '0;
                        state_next = ST_SQRT;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            ST_SQRT:
            begin
                if (go)
                begin
                    if (sqrt_res == '0)
                    begin
                        ovf_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_ACTP;
                    end
                end
            end
            ST_ACTP: if (go) state_next = ST_ACTS;
            ST_ACTS: if (go) state_next = ST_DIP;
            ST_DIP:  if (go) state_next = ST_DIS;
            ST_DIS:  if (go) state_next = ST_DRP;
            ST_DRP:  if (go) state_next = ST_DRS;
            ST_DRS:  if (go) state_next = ST_DR1;
            ST_DR1:  if (go) state_next = ST_TT;
            ST_TT:   if (go) state_next = ST_P1;
            ST_P1:   if (go) state_next = ST_S1;
            ST_S1:   if (go) state_next = ST_RP2;
            ST_RP2:
            begin
                if (mul_done)
                begin
                    ovf_next = ovf_next | p2_s.ovf;
                end
                if (go) state_next = ST_RS2;
            end
            ST_RS2:
            begin
                if (mul_done)
                begin
                    ovf_next = ovf_next | p2_s.ovf;
                end
                if (go) state_next = ST_W;
            end
            ST_W:
            begin
                ovf_next   = ovf_next | w1_s.ovf | w2a_s.ovf;
                state_next = ST_W2;
            end
            ST_W2:   if (go) state_next = ST_I2;
            ST_I2:   if (go) state_next = ST_I3;
            ST_I3:   if (go) state_next = ST_I4;
            ST_I4:   if (go) state_next = ST_I5;
            ST_I5:   if (go) state_next = ST_DA;
            ST_DA:   if (go) state_next = ST_DB;
            ST_DB:
            begin
                if (go)
                begin
                    ovf_next   = ovf_next | diag_s.ovf;
                    k_next     = '0;
                    state_next = ST_XX;
                end
            end
            ST_XX:   if (go) state_next = ST_A1;
            ST_A1:   if (go) state_next = ST_A;
            ST_A:    if (go) state_next = ST_B1;
            ST_B1:   if (go) state_next = ST_B2;
            ST_B2:   if (go) state_next = ST_B;
            ST_B:
            begin
                if (go)
                begin
                    ovf_next   = ovf_next | e_s.ovf;
                    state_next = ST_E;
                end
            end
            ST_E:
            begin
                if (k_reg inside {[3'd0:3'd2]})
                begin
                    ovf_next = ovf_next | e2_s.ovf;
                end
                state_next = ST_PW;
            end
            ST_PW:
            begin
                if (go)
                begin
                    acc_next[k_reg] = acc_s.val;
                    ovf_next        = ovf_next | acc_s.ovf;
                    if (k_reg == 3'(NUM_PAIRS - 1))
                    begin
                        k_next     = '0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_XX;
                    end
                end
            end
            ST_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    ovf_next       = 1'b0;
                    for (int i = 0; i < NUM_PAIRS; i++)
                    begin
                        acc_next[i] = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            for (int i = 0; i < NUM_PAIRS; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    dx_reg    <= q_data.d_x;
                    dy_reg    <= q_data.d_y;
                    dz_reg    <= q_data.d_z;
                    w_reg     <= q_data.weight;
                    last_reg  <= q_data.last;
                    sum_reg   <= '0;
                    act_p_reg <= 1'b0;
                    act_s_reg <= 1'b0;
                    p1_reg    <= '0;
                    s1_reg    <= '0;
                    p2_reg    <= '0;
                    s2_reg    <= '0;
                end
            end
            ST_SQ:   if (mul_done) sum_reg <= sum_reg + $unsigned(mres);
            ST_SQRT: if (sqrt_done) r_reg <= sqrt_res;
            ST_ACTP: if (mul_done) act_p_reg <= $unsigned(mres) > rsh;
            ST_ACTS: if (mul_done) act_s_reg <= $unsigned(mres) > rsh;
            ST_DIP:  if (div_done) inv_p_reg <= $signed(dquot);
            ST_DIS:  if (div_done) inv_s_reg <= $signed(dquot);
            ST_DRP:  if (div_done) rp_reg <= $signed(dquot);
            ST_DRS:  if (div_done) rs_reg <= $signed(dquot);
            ST_DR1:  if (div_done) inv1_reg <= $signed(dquot);
            ST_TT:   if (mul_done) tt_reg <= mres;
            ST_P1:   if (mul_done) p1_reg <= mres;
            ST_S1:   if (mul_done) s1_reg <= mres;
            ST_RP2:  if (mul_done) p2_reg <= p2_s.val;
            ST_RS2:  if (mul_done) s2_reg <= p2_s.val;
            ST_W:
            begin
                w1_reg  <= w1_s.val;
                tmp_reg <= w2a_s.val;
            end
            ST_W2:   if (mul_done) w2_reg <= mres;
            ST_I2:   if (mul_done) tmp_reg <= mres;
            ST_I3:   if (mul_done) inv3_reg <= mres;
            ST_I4:   if (mul_done) tmp_reg <= mres;
            ST_I5:   if (mul_done) inv5_reg <= mres;
            ST_DA:   if (mul_done) tmp_reg <= mres;
            ST_DB:   if (mul_done) diag_reg <= diag_s.val;
            ST_XX:   if (mul_done) xx_reg <= mres;
            ST_A1:   if (mul_done) tmp_reg <= mres;
            ST_A:    if (mul_done) a_reg <= mres;
            ST_B1:   if (mul_done) tmp_reg <= mres;
            ST_B2:   if (mul_done) tmp_reg <= mres;
            ST_B:    if (mul_done) e_reg <= e_s.val;
            ST_E:    if (k_reg inside {[3'd0:3'd2]}) e_reg <= e2_s.val;
            ST_FIN:
            begin
                if (load_out)
                begin
                    out_reg.m_xx     <= acc_reg[0];
                    out_reg.m_yy     <= acc_reg[1];
                    out_reg.m_zz     <= acc_reg[2];
                    out_reg.m_xy     <= acc_reg[3];
                    out_reg.m_xz     <= acc_reg[4];
                    out_reg.m_yz     <= acc_reg[5];
                    out_reg.overflow <= ovf_reg;
                end
            end
            default: ;
        endcase
    end

    ekq_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (use_mul & ~skip & ~issued_reg),
        .a        (mul_a),
        .b        (mul_b),
        .shift_en (mul_sh),
        .done     (mul_done),
        .res      (mres),
        .sat      (mul_sat)
    );

    ekq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (use_div & ~issued_reg),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (dquot)
    );

    ekq_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (use_sqrt & ~issued_reg),
        .val   (sum_reg),
        .done  (sqrt_done),
        .root  (sqrt_res)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/core/elastodynamic_kernel_quadrature_top.sv
// Top level of the elastodynamic kernel quadrature block: configuration registers,
// front end, node queue and back end. Depends on ekq_pkg, ekq_front, ekq_queue, ekq_back.
//
// Usage:
//   Configuration: write ext_x, ext_y, ext_z, time_now, speed_p, speed_s through
//   cfg_valid/cfg_index/cfg_data while the block is idle; cfg_ready is always high,
//   writes to indexes above five are dropped.
//   Nodes: in_valid/in_data, transfer when in_valid is high and in_stall low. The front
//   forms the distance vector and places the node in a two-entry queue, so two nodes
//   can be taken while the back end works.
//   Results: one transfer on out_valid/out_data per node marked last, holding the six
//   accumulated entries and the overflow flag; sums and flag then restart from zero.
//   Node processing: the back end takes one node at a time, its time set by the shared
//   multi-cycle multiplier (about 60 products), the bit-serial divider (five quotients)
//   and the square root. A node with zero distance ends after the square root and sets
//   the overflow flag. The result register and out_valid are loaded when the back end
//   finishes the last node of a set.
//   Receiver stall: the result register holds; the back end waits at the next set end.
//   Reset: configuration returns to zero with both speeds at 1.0, queue, sums and flag
//   are cleared.
module elastodynamic_kernel_quadrature_top #(
    parameter int FRAC_BITS = ekq_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  ekq_pkg::node_t   in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output ekq_pkg::result_t out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import ekq_pkg::*;

    cfg_t  cfg_reg;
    logic  q_push, q_full, q_pop, q_not_empty;
    qent_t q_in, q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ext_x    <= '0;
            cfg_reg.ext_y    <= '0;
            cfg_reg.ext_z    <= '0;
            cfg_reg.time_now <= '0;
            cfg_reg.speed_p  <= 31'(1) << FRAC_BITS;
            cfg_reg.speed_s  <= 31'(1) << FRAC_BITS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_EXT_X:    cfg_reg.ext_x    <= cfg_data;
                CFG_EXT_Y:    cfg_reg.ext_y    <= cfg_data;
                CFG_EXT_Z:    cfg_reg.ext_z    <= cfg_data;
                CFG_TIME_NOW: cfg_reg.time_now <= cfg_data;
                CFG_SPEED_P:  cfg_reg.speed_p  <= cfg_data[30:0];
                CFG_SPEED_S:  cfg_reg.speed_s  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    ekq_front u_front (
        .node       (in_data),
        .node_valid (in_valid),
        .node_stall (in_stall),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    ekq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    ekq_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_not_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: sim/elastodynamic_kernel_quadrature_top_tb.sv
// Self-checking testbench for elastodynamic_kernel_quadrature_top: directed table, then
// random quadrature sets under sender idling, receiver stalls and a long receiver hold-off.
// Depends on ekq_pkg and the RTL top level; results are checked against a local kernel model.
module elastodynamic_kernel_quadrature_top_tb;
    import ekq_pkg::*;

    localparam int          FB          = 16;
    localparam int          SETTLE      = 2000;
    localparam longint      CYCLE_LIMIT = 6000000;
    localparam int          HOLD_CYCLES = 20000;
    localparam logic [2:0]  CFG_SPARE_6 = 3'd6;
    localparam logic [2:0]  CFG_SPARE_7 = 3'd7;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  index;
        logic [31:0] data;
        node_t       node;
        bit          typed;
        result_t     res;
    } row_t;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    node_t   in_data;
    logic    out_valid;
    logic    out_stall;
    result_t out_data;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // kernel model state
    logic signed [31:0] k_ext [3];
    logic signed [31:0] k_time;
    logic [30:0]        k_sp;
    logic [30:0]        k_ss;
    logic signed [63:0] k_acc [6];
    bit                 k_ovf;

    result_t sums_due[$];
    int      errors;
    int      idle_pct;
    int      stall_pct;
    int      hold_req;
    int      hold_seen;
    int      hold_cnt;
    longint  cycles;
    row_t    rows[$];

    elastodynamic_kernel_quadrature_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [63:0] sat_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b, input int sh);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [63:0]  lim;
        logic [63:0]  lo;
        logic [127:0] p;
        bit           neg;
        ua  = a[63] ? 64'(-a) : a;
        ub  = b[63] ? 64'(-b) : b;
        neg = a[63] ^ b[63];
        p   = {64'd0, ua} * {64'd0, ub};
        p   = p >> sh;
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
        if (p[127:64] != 0 || p[63:0] > lim)
        begin
            k_ovf = 1'b1;
            lo = lim;
        end
        else
            lo = p[63:0];
        return neg ? -$signed(lo) : $signed(lo);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            k_ovf = 1'b1;
            s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
        end
        return s;
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
        begin
            k_ovf = 1'b1;
            s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
        end
        return s;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic void kernel_cfg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            CFG_EXT_X:    k_ext[0] = val;
            CFG_EXT_Y:    k_ext[1] = val;
            CFG_EXT_Z:    k_ext[2] = val;
            CFG_TIME_NOW: k_time   = val;
            CFG_SPEED_P:  k_sp     = val[30:0];
            CFG_SPEED_S:  k_ss     = val[30:0];
            default:      ;
        endcase
    endfunction

    // add one node into the sums; return 1 with the set totals on the last node
    function automatic bit kernel_node(input node_t n, output result_t res);
        logic signed [31:0] crd [3];
        logic signed [63:0] d [3];
        logic signed [63:0] v, t, w, one, three, half;
        logic signed [63:0] inv_p, inv_s, rp, rs, tt, p1, s1, p2, s2, w1, w2;
        logic signed [63:0] inv1, inv3, inv5, diag, xx, a, b, e;
        logic [63:0]        sum, r, cp, cs, rsh, mg;
        bit                 act_p, act_s;
        int                 ri [6];
        int                 ci [6];
        ri = '{0, 1, 2, 0, 0, 1};
        ci = '{0, 1, 2, 1, 2, 2};
        crd[0] = n.node_x;
        crd[1] = n.node_y;
        crd[2] = n.node_z;
        sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            v = 64'(crd[k]) - 64'(k_ext[k]);
            if (v > 64'sd2147483647)
            begin
                v = 64'sd2147483647;
                k_ovf = 1'b1;
            end
            if (v < -64'sd2147483648)
            begin
                v = -64'sd2147483648;
                k_ovf = 1'b1;
            end
            d[k] = v;
            mg   = v[63] ? 64'(-v) : v;
            sum  = sum + mg * mg;
        end
        r  = floor_sqrt(sum);
        t  = 64'(k_time);
        w  = 64'(n.weight);
        cp = (k_sp == 0) ? 64'd1 : 64'(k_sp);
        cs = (k_ss == 0) ? 64'd1 : 64'(k_ss);
        if (r == 0)
            k_ovf = 1'b1;
        else
        begin
            one   = 64'sd1 << FB;
            three = 3 * one;
            half  = one >>> 1;
            rsh   = r << FB;
            act_p = t > 0 && 64'(t) * cp > rsh;
            act_s = t > 0 && 64'(t) * cs > rsh;
            inv_p = (64'd1 << (2 * FB)) / cp;
            inv_s = (64'd1 << (2 * FB)) / cs;
            rp    = rsh / cp;
            rs    = rsh / cs;
            tt    = sat_mul(t, t, FB);
            p1    = act_p ? sat_mul(inv_p, inv_p, FB) : 0;
            s1    = act_s ? sat_mul(inv_s, inv_s, FB) : 0;
            p2    = act_p ? sat_sub(tt, sat_mul(rp, rp, FB)) : 0;
            s2    = act_s ? sat_sub(tt, sat_mul(rs, rs, FB)) : 0;
            w1    = sat_sub(p1, s1);
            w2    = sat_mul(half, sat_sub(p2, s2), FB);
            inv1  = (64'd1 << (2 * FB)) / r;
            inv3  = sat_mul(sat_mul(inv1, inv1, FB), inv1, FB);
            inv5  = sat_mul(sat_mul(inv3, inv1, FB), inv1, FB);
            diag  = sat_sub(sat_mul(inv1, s1, FB), sat_mul(inv3, w2, FB));
            for (int k = 0; k < 6; k++)
            begin
                xx = sat_mul(d[ri[k]], d[ci[k]], FB);
                a  = sat_mul(sat_mul(xx, inv3, FB), w1, FB);
                b  = sat_mul(sat_mul(sat_mul(three, xx, FB), inv5, FB), w2, FB);
                e  = sat_add(a, b);
                if (k < 3)
                    e = sat_add(e, diag);
                k_acc[k] = sat_add(k_acc[k], sat_mul(e, w, 0));
            end
        end
        res = '0;
        if (!n.last)
            return 1'b0;
        res.m_xx = k_acc[0];
        res.m_yy = k_acc[1];
        res.m_zz = k_acc[2];
        res.m_xy = k_acc[3];
        res.m_xz = k_acc[4];
        res.m_yz = k_acc[5];
        res.overflow = k_ovf;
        for (int k = 0; k < 6; k++)
            k_acc[k] = 0;
        k_ovf = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_node(input node_t n, input bit typed, input result_t typed_res);
        result_t res;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= n;
        do
            @(posedge clk);
        while (in_stall);
        if (kernel_node(n, res))
            sums_due.push_back(typed ? typed_res : res);
    endtask

    // hold until the block has drained, then keep the node input quiet
    task automatic quiesce();
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (sums_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        kernel_cfg(idx, val);
    endtask

    function automatic logic [31:0] near(input logic [31:0] centre, input int span);
        return centre + 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    task automatic random_sets(input int count);
        node_t   n;
        result_t none;
        int      left;
        none = '0;
        left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (left == 0)
                left = $urandom_range(1, 6);
            left--;
            if ($urandom_range(99) < 15)
            begin
                n.node_x = $urandom;
                n.node_y = $urandom;
                n.node_z = $urandom;
                n.weight = $urandom;
            end
            else
            begin
                n.node_x = near(k_ext[0], 32'h10_0000);
                n.node_y = near(k_ext[1], 32'h10_0000);
                n.node_z = near(k_ext[2], 32'h10_0000);
                n.weight = near(32'h0, 32'h4_0000);
            end
            n.last = (left == 0) || (i == count - 1) || ($urandom_range(99) < 5);
            if (n.last)
                left = 0;
            send_node(n, 1'b0, none);
        end
    endtask

    task automatic random_cfg(input int phase);
        logic [31:0] v [6];
        v[0] = near(32'h0, 32'h3e8_0000);
        v[1] = near(32'h0, 32'h3e8_0000);
        v[2] = near(32'h0, 32'h3e8_0000);
        v[3] = $urandom_range(0, 32'h32_0000);
        v[4] = $urandom_range(32'h8000, 32'h8_0000);
        v[5] = $urandom_range(32'h8000, 32'h8_0000);
        case (phase)
            1:
            begin
                v[0] = 32'h7fff_ffff;
                v[1] = 32'h8000_0000;
                v[3] = 32'h7fff_ffff;
                v[4] = 32'h7fff_ffff;
                v[5] = 32'h1;
            end
            2:
            begin
                v[3] = $urandom;
                v[4] = $urandom;
                v[5] = $urandom;
            end
            default: ;
        endcase
        quiesce();
        write_reg(CFG_EXT_X, v[0]);
        write_reg(CFG_EXT_Y, v[1]);
        write_reg(CFG_EXT_Z, v[2]);
        write_reg(CFG_TIME_NOW, v[3]);
        write_reg(CFG_SPEED_P, v[4]);
        write_reg(CFG_SPEED_S, v[5]);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic row_t node_row(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input logic [31:0] w,
                                      input bit last);
        row_t rw;
        rw = '{default: '0};
        rw.node = '{node_x: x, node_y: y, node_z: z, weight: w, last: last};
        return rw;
    endfunction

    function automatic row_t cfg_row(input logic [2:0] idx, input logic [31:0] val);
        row_t rw;
        rw = '{default: '0};
        rw.is_cfg = 1'b1;
        rw.index  = idx;
        rw.data   = val;
        return rw;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (sums_due.size() == 0)
            begin
                $error("result transfer with no set pending");
                errors++;
            end
            else
            begin
                exp_r = sums_due.pop_front();
                check_field("m_xx", exp_r.m_xx, out_data.m_xx);
                check_field("m_yy", exp_r.m_yy, out_data.m_yy);
                check_field("m_zz", exp_r.m_zz, out_data.m_zz);
                check_field("m_xy", exp_r.m_xy, out_data.m_xy);
                check_field("m_xz", exp_r.m_xz, out_data.m_xz);
                check_field("m_yz", exp_r.m_yz, out_data.m_yz);
                check_field("overflow", 64'(exp_r.overflow), 64'(out_data.overflow));
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_cnt  = HOLD_CYCLES;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        result_t known;
        errors    = 0;
        cycles    = 0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 0;
        hold_seen = 0;
        hold_cnt  = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_EXT_X;
        cfg_data  = '0;
        k_ext     = '{0, 0, 0};
        k_time    = 0;
        k_sp      = 31'h1_0000;
        k_ss      = 31'h1_0000;
        k_acc     = '{0, 0, 0, 0, 0, 0};
        k_ovf     = 1'b0;

        known = '0;
        known.overflow = 1'b1;
        rows.push_back(node_row(32'h0, 32'h0, 32'h0, 32'h1_0000, 1'b1));
        rows[$].typed = 1'b1;
        rows[$].res   = known;
        rows.push_back(node_row(32'h1_0000, 32'h0, 32'h0, 32'h1_0000, 1'b0));
        rows.push_back(node_row(32'h0, 32'h2_0000, 32'h0, 32'hffff_0000, 1'b0));
        rows.push_back(node_row(32'h0, 32'h0, 32'hfffd_0000, 32'h7fff_ffff, 1'b1));
        rows.push_back(node_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                32'h8000_0000, 1'b1));
        rows.push_back(node_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7fff_ffff, 1'b1));
        rows.push_back(cfg_row(CFG_TIME_NOW, 32'ha_0000));
        rows.push_back(node_row(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b0));
        rows.push_back(node_row(32'h2_0000, 32'hffff_0000, 32'h8000, 32'h8000, 1'b1));
        rows.push_back(cfg_row(CFG_SPEED_P, 32'h0));
        rows.push_back(cfg_row(CFG_SPEED_S, 32'h7fff_ffff));
        rows.push_back(node_row(32'h3_0000, 32'h4_0000, 32'h0, 32'h1_0000, 1'b1));
        rows.push_back(cfg_row(CFG_EXT_X, 32'h7fff_ffff));
        rows.push_back(cfg_row(CFG_EXT_Y, 32'h8000_0000));
        rows.push_back(cfg_row(CFG_EXT_Z, 32'h1_2345));
        rows.push_back(node_row(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1_0000, 1'b1));
        rows.push_back(cfg_row(CFG_SPARE_6, 32'hffff_ffff));
        rows.push_back(cfg_row(CFG_SPARE_7, 32'h5555_aaaa));
        rows.push_back(node_row(32'h7fff_ffff, 32'h8000_0000, 32'h1_2345, 32'h1_0000, 1'b1));
        rows[$].typed = 1'b1;
        rows[$].res   = known;
        rows.push_back(cfg_row(CFG_TIME_NOW, 32'h8000_0000));
        rows.push_back(node_row(32'h0, 32'h0, 32'h0, 32'h1_0000, 1'b1));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                quiesce();
                write_reg(rows[i].index, rows[i].data);
                cfg_valid <= 1'b0;
                @(posedge clk);
            end
            else
                send_node(rows[i].node, rows[i].typed, rows[i].res);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            random_cfg(ph);
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 33 : 47) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 33 : 47) : 0;
            if (ph == 1)
                idle_pct = 47;
            random_sets(280);
        end

        random_cfg(0);
        idle_pct  = 0;
        stall_pct = 0;
        hold_req++;
        for (int i = 0; i < 10; i++)
            random_sets(1);

        in_valid <= 1'b0;
        @(posedge clk);
        while (sums_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ekq_pkg.sv
rtl/core/ekq_front.sv
rtl/core/ekq_queue.sv
rtl/core/ekq_mul.sv
rtl/core/ekq_div.sv
rtl/core/ekq_sqrt.sv
rtl/core/ekq_back.sv
rtl/core/elastodynamic_kernel_quadrature_top.sv
sim/elastodynamic_kernel_quadrature_top_tb.sv
